>>> rtl/kruskal_norm_squared_assert.svh
// Assertion macros shared by the checker file.
`ifndef KRUSKAL_NORM_SQUARED_ASSERT_SVH
`define KRUSKAL_NORM_SQUARED_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define KNS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define KNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kns_pkg.sv
package kns_pkg;

  localparam int RANK_MAX_DEF  = 16;
  localparam int MODES_MAX_DEF = 8;

  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int NORM_W  = 63;
  localparam int RANK_W  = 5;
  localparam int MCNT_W  = 4;
  localparam int CFG_IW  = 8;
  localparam int CFG_DW  = 32;

  localparam logic [RANK_W-1:0] RANK_RESET = 5'd16;
  localparam logic [MCNT_W-1:0] MCNT_RESET = 4'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_RANK_IN_USE = 8'd0;
  localparam logic [CFG_IW-1:0] REG_MODE_COUNT  = 8'd1;

  // request codes
  localparam logic [1:0] REQ_GRAM    = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [2:0]              mode_index;
    logic [3:0]              row_index;
    logic [3:0]              col_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm_squared;
    logic              saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    MUL_GRAM,
    MUL_T1,
    MUL_T2
  } mul_sel_e;

  typedef struct packed {
    logic     latch_item;
    logic     sel_cmp;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     p_wr_direct;
    logic     p_wr_prod;
    logic     w_wr;
    logic     t1_en;
    logic     acc_clr;
    logic     acc_en;
    logic     idx_clr;
    logic     idx_step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       gram_ok;
    logic       gram_mode0;
    logic       weight_ok;
    logic       rank_zero;
    logic       last_term;
  } dp_status_t;

endpackage

>>> rtl/kns_ram.sv
module kns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kns_ctrl.sv
module kns_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  kns_pkg::dp_status_t status_i,
  output kns_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_G_MUL,
    ST_G_WR,
    ST_C_RD,
    ST_C_MUL1,
    ST_C_SAT1,
    ST_C_MUL2,
    ST_C_ACC,
    ST_C_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = kns_pkg::MUL_GRAM;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        state_d = ST_IDLE;
        case (status_i.req_type)
          kns_pkg::REQ_GRAM: begin
            if (status_i.gram_ok) begin
              if (status_i.gram_mode0) begin
                cmd_o.p_wr_direct = 1'b1;
              end else begin
                state_d = ST_G_MUL;
              end
            end
          end
          kns_pkg::REQ_WEIGHT: begin
            cmd_o.w_wr = status_i.weight_ok;
          end
          kns_pkg::REQ_COMPUTE: begin
            cmd_o.idx_clr = 1'b1;
            cmd_o.acc_clr = 1'b1;
            state_d = status_i.rank_zero ? ST_C_OUT : ST_C_RD;
          end
          default: ;
        endcase
      end
      ST_G_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kns_pkg::MUL_GRAM;
        state_d = ST_G_WR;
      end
      ST_G_WR: begin
        cmd_o.p_wr_prod = 1'b1;
        state_d = ST_IDLE;
      end
      ST_C_RD: begin
        cmd_o.sel_cmp = 1'b1;
        state_d = ST_C_MUL1;
      end
      ST_C_MUL1: begin
        cmd_o.sel_cmp = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kns_pkg::MUL_T1;
        state_d = ST_C_SAT1;
      end
      ST_C_SAT1: begin
        cmd_o.sel_cmp = 1'b1;
        cmd_o.t1_en   = 1'b1;
        state_d = ST_C_MUL2;
      end
      ST_C_MUL2: begin
        cmd_o.sel_cmp = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = kns_pkg::MUL_T2;
        state_d = ST_C_ACC;
      end
      ST_C_ACC: begin
        cmd_o.sel_cmp  = 1'b1;
        cmd_o.acc_en   = 1'b1;
        cmd_o.idx_step = 1'b1;
        state_d = status_i.last_term ? ST_C_OUT : ST_C_RD;
      end
      ST_C_OUT: begin
        // hold the finished sum until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/kns_dp.sv
module kns_dp #(
  parameter int RANK_MAX  = kns_pkg::RANK_MAX_DEF,
  parameter int MODES_MAX = kns_pkg::MODES_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kns_pkg::in_item_t            in_data_i,
  output kns_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [kns_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [kns_pkg::CFG_DW-1:0]   cfg_data_i,
  input  kns_pkg::dp_cmd_t             cmd_i,
  output kns_pkg::dp_status_t          status_o
);

  localparam int IW    = RANK_MAX > 1 ? $clog2(RANK_MAX) : 1;
  localparam int PD    = RANK_MAX * RANK_MAX;
  localparam int AW    = PD > 1 ? $clog2(PD) : 1;
  localparam int RW    = $clog2(RANK_MAX + 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(RANK_MAX);
  localparam logic [RW-1:0] R_CAP      = RW'(RANK_MAX);
  localparam logic signed [kns_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(kns_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [kns_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(kns_pkg::ACC_W-1){1'b0}}};

  kns_pkg::in_item_t item_q;
  logic [kns_pkg::RANK_W-1:0] rank_q;
  logic [kns_pkg::MCNT_W-1:0] mcnt_q;

  logic [IW-1:0] i_q, j_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] t1_q;
  logic signed [kns_pkg::ACC_W-1:0] acc_q;
  kns_pkg::out_item_t out_q;
  logic sat_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= kns_pkg::RANK_RESET;
      mcnt_q <= kns_pkg::MCNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kns_pkg::REG_RANK_IN_USE: rank_q <= cfg_data_i[kns_pkg::RANK_W-1:0];
        kns_pkg::REG_MODE_COUNT:  mcnt_q <= cfg_data_i[kns_pkg::MCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_data_i;
    end
  end

  // item decode
  logic row_in, col_in;
  assign row_in = (32'(item_q.row_index) < RANK_MAX);
  assign col_in = (32'(item_q.col_index) < RANK_MAX);

  assign status_o.req_type   = item_q.req_type;
  assign status_o.gram_ok    = (item_q.col_index >= item_q.row_index) && row_in && col_in
                               && (4'(item_q.mode_index) < mcnt_q)
                               && (32'(item_q.mode_index) < MODES_MAX);
  assign status_o.gram_mode0 = (item_q.mode_index == 3'd0);
  assign status_o.weight_ok  = row_in;

  // effective rank and triangle walk
  logic [RW-1:0] r_eff, r_last;
  logic last_j, last_i;
  assign r_eff  = (32'(rank_q) > RANK_MAX) ? R_CAP : RW'(rank_q);
  assign r_last = r_eff - RW'(1);
  assign last_j = (RW'(j_q) == r_last);
  assign last_i = (RW'(i_q) == r_last);
  assign status_o.rank_zero = (r_eff == '0);
  assign status_o.last_term = last_i && last_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.idx_clr) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.idx_step) begin
      if (last_j) begin
        i_q <= i_q + IW'(1);
        j_q <= i_q + IW'(1);
      end else begin
        j_q <= j_q + IW'(1);
      end
    end
  end

  // stores
  logic [AW-1:0] g_addr, c_addr, p_raddr;
  logic [31:0]   p_rdata, p_wdata, wi_rdata, wj_rdata;
  logic [IW-1:0] w_waddr;
  logic          p_we;
  logic [31:0]   prod_sat;
  logic          prod_sat_hit;

  assign g_addr  = AW'(item_q.row_index) * ROW_STRIDE + AW'(item_q.col_index);
  assign c_addr  = AW'(i_q) * ROW_STRIDE + AW'(j_q);
  assign p_raddr = cmd_i.sel_cmp ? c_addr : g_addr;
  assign p_we    = cmd_i.p_wr_direct || cmd_i.p_wr_prod;
  assign p_wdata = cmd_i.p_wr_direct ? item_q.value : prod_sat;
  assign w_waddr = IW'(item_q.row_index);

  kns_ram #(.WIDTH(32), .DEPTH(PD)) u_prod_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (g_addr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // weights kept twice so w[i] and w[j] read in the same cycle
  kns_ram #(.WIDTH(32), .DEPTH(RANK_MAX)) u_wi_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.w_wr),
    .waddr_i (w_waddr),
    .wdata_i (item_q.value),
    .raddr_i (i_q),
    .rdata_o (wi_rdata)
  );

  kns_ram #(.WIDTH(32), .DEPTH(RANK_MAX)) u_wj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.w_wr),
    .waddr_i (w_waddr),
    .wdata_i (item_q.value),
    .raddr_i (j_q),
    .rdata_o (wj_rdata)
  );

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;

  always_comb begin
    mul_a = $signed(p_rdata);
    mul_b = item_q.value;
    case (cmd_i.mul_sel)
      kns_pkg::MUL_GRAM: begin
        mul_a = $signed(p_rdata);
        mul_b = item_q.value;
      end
      kns_pkg::MUL_T1: begin
        mul_a = $signed(p_rdata);
        mul_b = $signed(wi_rdata);
      end
      kns_pkg::MUL_T2: begin
        mul_a = t1_q;
        mul_b = $signed(wj_rdata);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // >>>16 then clamp to Q16.16: out of range unless bits 63..47 agree
  assign prod_sat_hit = !((&prod_q[63:47]) || !(|prod_q[63:47]));
  assign prod_sat     = prod_sat_hit ? (prod_q[63] ? 32'h8000_0000 : 32'h7fff_ffff)
                                     : prod_q[47:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.t1_en) begin
      t1_q <= $signed(prod_sat);
    end
  end

  // saturating accumulate
  logic signed [kns_pkg::ACC_W-1:0] t2, term, sum;
  logic acc_ovf;

  assign t2      = {{16{prod_q[63]}}, prod_q[63:16]};
  assign term    = (i_q != j_q) ? {t2[kns_pkg::ACC_W-2:0], 1'b0} : t2;
  assign sum     = acc_q + term;
  assign acc_ovf = (acc_q[63] == term[63]) && (sum[63] != acc_q[63]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_ovf ? (acc_q[63] ? ACC_MIN : ACC_MAX) : sum;
    end
  end

  // magnitude
  logic acc_is_min;
  logic [kns_pkg::ACC_W-1:0] mag;
  assign acc_is_min = (acc_q == ACC_MIN);
  assign mag = !acc_q[63] ? acc_q : (acc_is_min ? ACC_MAX : -acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.norm_squared <= mag[kns_pkg::NORM_W-1:0];
      out_q.saturated    <= sat_q || acc_is_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_q
               || ((cmd_i.p_wr_prod || cmd_i.t1_en) && prod_sat_hit)
               || (cmd_i.acc_en && acc_ovf);
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/kruskal_norm_squared.sv
// channel  dir  handshake                  payload / fields
// in       in   in_valid_i / in_stall_o    kns_pkg::in_item_t in_data_i
// out      out  out_valid_o / out_stall_i  kns_pkg::out_item_t out_data_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Compute walks r*(r+1)/2 triangle terms with r = min(rank_in_use, RANK_MAX),
// then waits for the output register; one shared 32x32 multiplier and the
// registered store reads serve every term.
// Reset: async, active low; config returns to rank 16, modes 3, flag clear.
// Stores need no clearing pass. Input stalls while an item is in work;
// a waiting output beat only blocks the end of the next compute.
module kruskal_norm_squared #(
  parameter int RANK_MAX  = kns_pkg::RANK_MAX_DEF,
  parameter int MODES_MAX = kns_pkg::MODES_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  kns_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kns_pkg::out_item_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kns_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [kns_pkg::CFG_DW-1:0] cfg_data_i
);

  kns_pkg::dp_cmd_t    cmd;
  kns_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  kns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kns_dp #(
    .RANK_MAX  (RANK_MAX),
    .MODES_MAX (MODES_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> rtl/kns_checker.sv
`include "kruskal_norm_squared_assert.svh"

module kns_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input kns_pkg::out_item_t out_data_o,
  input logic               cfg_ready_o
);

  // stalled output beat holds
  `KNS_ASSERT(a_out_hold, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
              "output beat changed under stall")

  // an accepted item keeps the input stalled while it is decoded
  `KNS_ASSERT(a_busy_after_accept, clk_i, rst_ni,
              in_valid_i && !in_stall_o |=> in_stall_o,
              "input not stalled after accept")

  // a new result comes only from a compute in progress
  `KNS_ASSERT(a_result_from_work, clk_i, rst_ni,
              $rose(out_valid_o) |-> $past(in_stall_o),
              "result appeared while idle")

  // config port never back-pressures
  `KNS_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "config port not ready")

endmodule

bind kruskal_norm_squared kns_checker u_kns_checker (.*);
